// ===== design/ibfd_pkg.sv =====
// ----------------------------------------------------------------------------
// ibfd_pkg
// Shared types and constants of the inertial sensor burst frame decoder.
// ----------------------------------------------------------------------------
package ibfd_pkg;

  // Input item kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_SUPPLY_MIN = 2'd0;
  localparam logic [1:0] REG_SUPPLY_MAX = 2'd1;
  localparam logic [1:0] REG_BAD_LIMIT  = 2'd2;
  localparam logic [1:0] REG_HOLDOFF    = 2'd3;

  // Configuration reset values (supply window is 4.25 V .. 5.25 V at 2.418 mV/count)
  localparam logic [13:0] SUPPLY_MIN_RST = 14'd1758;
  localparam logic [13:0] SUPPLY_MAX_RST = 14'd2171;
  localparam logic [11:0] BAD_LIMIT_RST  = 12'd2000;
  localparam logic [9:0]  HOLDOFF_RST    = 10'd250;

  // Frame layout
  localparam logic [4:0] LAST_BYTE_POS = 5'd23;
  localparam logic [3:0] WORD_SUPPLY   = 4'd0;
  localparam logic [3:0] WORD_LAST_IMU = 4'd9;
  localparam logic [3:0] WORD_TEMP     = 4'd10;
  localparam logic [3:0] WORD_ADC      = 4'd11;

  typedef struct packed {
    logic       opcode;
    logic       frame_start;
    logic [7:0] rx_byte;
  } ibfd_item_t;

  typedef struct packed {
    logic [13:0] supply_min_count;
    logic [13:0] supply_max_count;
    logic [11:0] bad_frame_limit;
    logic [9:0]  holdoff_ticks;
  } ibfd_cfg_t;

  typedef struct packed {
    logic [3:0]         word_index;
    logic signed [14:0] word_value;
    logic               frame_good;
    logic               sensor_reset;
    logic               last_word;
  } ibfd_result_t;

endpackage

// ===== design/ibfd_word_decode.sv =====
// ----------------------------------------------------------------------------
// ibfd_word_decode
// Combinational decode of one byte pair into a record word value.
// ----------------------------------------------------------------------------
module ibfd_word_decode
  import ibfd_pkg::*;
(
  input  logic [3:0]         word_index_i,
  input  logic [7:0]         high_byte_i,
  input  logic [7:0]         low_byte_i,
  output logic [13:0]        supply_count_o,
  output logic signed [14:0] word_value_o
);

  logic [13:0] raw14;
  logic [11:0] raw12;

  assign raw14          = {high_byte_i[5:0], low_byte_i};
  assign raw12          = {high_byte_i[3:0], low_byte_i};
  assign supply_count_o = raw14;

  always_comb begin
    if (word_index_i == WORD_SUPPLY) begin
      word_value_o = $signed({1'b0, raw14});
    end else if (word_index_i <= WORD_LAST_IMU) begin
      word_value_o = $signed({raw14[13], raw14});
    end else if (word_index_i == WORD_TEMP) begin
      word_value_o = $signed({{3{raw12[11]}}, raw12});
    end else begin
      word_value_o = $signed({3'b000, raw12});
    end
  end

endmodule

// ===== design/ibfd_frame_ctrl.sv =====
// ----------------------------------------------------------------------------
// ibfd_frame_ctrl
// Frame position, supply check, bad frame counter and reset holdoff.
// ----------------------------------------------------------------------------
module ibfd_frame_ctrl
  import ibfd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  ibfd_item_t   item_i,
  input  ibfd_cfg_t    cfg_i,
  output logic         res_valid_o,
  output ibfd_result_t res_o
);

  logic [4:0]  pos_q, pos_d, pos_eff;
  logic [7:0]  high_q, high_d;
  logic        good_q, good_d;
  logic        ignored_q, ignored_d;
  logic [11:0] bad_cnt_q, bad_cnt_d;
  logic [9:0]  holdoff_q, holdoff_d;

  logic        first_byte;
  logic        frame_ign;
  logic        good_base;
  logic [3:0]  word;
  logic [13:0] supply_count;
  logic signed [14:0] value;
  logic        in_window;
  logic [12:0] bad_next;
  logic        pulse;

  ibfd_word_decode u_decode (
    .word_index_i   (word),
    .high_byte_i    (high_q),
    .low_byte_i     (item_i.rx_byte),
    .supply_count_o (supply_count),
    .word_value_o   (value)
  );

  assign pos_eff    = (item_i.frame_start || pos_q > LAST_BYTE_POS) ? 5'd0 : pos_q;
  assign first_byte = (pos_eff == 5'd0);
  assign frame_ign  = first_byte ? (holdoff_q != 10'd0) : ignored_q;
  assign good_base  = first_byte ? 1'b0 : good_q;
  assign word       = pos_eff[4:1];
  assign in_window  = (supply_count >= cfg_i.supply_min_count) &&
                      (supply_count <= cfg_i.supply_max_count);
  assign bad_next   = {1'b0, bad_cnt_q} + 13'd1;

  always_comb begin
    pos_d       = pos_q;
    high_d      = high_q;
    good_d      = good_q;
    ignored_d   = ignored_q;
    bad_cnt_d   = bad_cnt_q;
    holdoff_d   = holdoff_q;
    pulse       = 1'b0;
    res_valid_o = 1'b0;

    if (item_i.opcode == OP_TICK) begin
      if (holdoff_q != 10'd0) begin
        holdoff_d = holdoff_q - 10'd1;
      end
    end else begin
      pos_d     = (pos_eff == LAST_BYTE_POS) ? 5'd0 : pos_eff + 5'd1;
      ignored_d = frame_ign;
      good_d    = good_base;
      if (!frame_ign) begin
        if (!pos_eff[0]) begin
          high_d = item_i.rx_byte;
        end else begin
          res_valid_o = 1'b1;
          if (word == WORD_SUPPLY) begin
            good_d = in_window;
            if (!in_window) begin
              if (bad_next > {1'b0, cfg_i.bad_frame_limit}) begin
                pulse     = 1'b1;
                bad_cnt_d = 12'd0;
                holdoff_d = cfg_i.holdoff_ticks;
              end else begin
                bad_cnt_d = bad_next[11:0];
              end
            end
          end
        end
      end
    end
  end

  assign res_o.word_index   = word;
  assign res_o.word_value   = value;
  assign res_o.frame_good   = good_d;
  assign res_o.sensor_reset = pulse;
  assign res_o.last_word    = (word == WORD_ADC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      high_q    <= '0;
      good_q    <= 1'b0;
      ignored_q <= 1'b0;
      bad_cnt_q <= '0;
      holdoff_q <= '0;
    end else if (step_i) begin
      pos_q     <= pos_d;
      high_q    <= high_d;
      good_q    <= good_d;
      ignored_q <= ignored_d;
      bad_cnt_q <= bad_cnt_d;
      holdoff_q <= holdoff_d;
    end
  end

endmodule

// ===== design/ibfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// ibfd_out_reg
// Result register with valid/ready handshake toward the consumer.
// ----------------------------------------------------------------------------
module ibfd_out_reg
  import ibfd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  ibfd_result_t data_i,
  input  logic         ready_i,
  output logic         free_o,
  output logic         valid_o,
  output ibfd_result_t data_o
);

  logic         valid_q, valid_d;
  ibfd_result_t data_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

// ===== design/imu_burst_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// imu_burst_frame_decoder
// Decodes a 24-byte inertial sensor burst response into 12 record words.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Payload
//  s_axis   in   tvalid / tready    tdata: rx_byte; tuser: opcode, frame_start
//  m_axis   out  tvalid / tready    tdata: word_value; tuser: word_index,
//                                   frame_good, sensor_reset; tlast: last_word
//  cfg      in   cfg_valid / ready  cfg_index (0..3), cfg_data
//
//  One transaction per cycle sustained while the output is not stalled: an
//  input register feeds the frame control logic, whose result is loaded
//  into the output register. Reset clears frame state, counters and control;
//  configuration returns to its defaults. A stalled output holds the input
//  stage, which in turn drops s_axis_tready; ticks and high bytes produce no
//  result but still advance.
// ----------------------------------------------------------------------------
module imu_burst_frame_decoder
  import ibfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser_i,   // [0] opcode, [1] frame_start
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [14:0] word_value, [15] zero
  output logic [5:0]  m_axis_tuser_o,   // [3:0] word_index, [4] frame_good,
                                        // [5] sensor_reset
  output logic        m_axis_tlast_o,   // last_word
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i
);

  // Input register
  logic         in_valid_q, in_valid_d;
  ibfd_item_t   in_item_q;
  logic         s_accept;
  logic         step;

  // Configuration registers
  ibfd_cfg_t    cfg_q, cfg_d;

  // Result path
  logic         res_valid;
  ibfd_result_t res;
  logic         out_free;
  logic         out_valid;
  ibfd_result_t out_data;

  // Advance the input stage whenever the output register can take a result.
  assign step            = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign in_valid_d      = s_accept || (in_valid_q && !step);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q.opcode      <= s_axis_tuser_i[0];
      in_item_q.frame_start <= s_axis_tuser_i[1];
      in_item_q.rx_byte     <= s_axis_tdata_i;
    end
  end

  // Configuration: always ready; each write is registered and takes effect in the next cycle.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SUPPLY_MIN: cfg_d.supply_min_count = cfg_data_i;
        REG_SUPPLY_MAX: cfg_d.supply_max_count = cfg_data_i;
        REG_BAD_LIMIT:  cfg_d.bad_frame_limit  = cfg_data_i[11:0];
        REG_HOLDOFF:    cfg_d.holdoff_ticks    = cfg_data_i[9:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.supply_min_count <= SUPPLY_MIN_RST;
      cfg_q.supply_max_count <= SUPPLY_MAX_RST;
      cfg_q.bad_frame_limit  <= BAD_LIMIT_RST;
      cfg_q.holdoff_ticks    <= HOLDOFF_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Decode the held item and update frame state.
  ibfd_frame_ctrl u_frame_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_item_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Hold the finished word until the consumer takes it.
  ibfd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step && res_valid),
    .data_i  (res),
    .ready_i (m_axis_tready_i),
    .free_o  (out_free),
    .valid_o (out_valid),
    .data_o  (out_data)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {1'b0, out_data.word_value};
  assign m_axis_tuser_o  = {out_data.sensor_reset, out_data.frame_good, out_data.word_index};
  assign m_axis_tlast_o  = out_data.last_word;

endmodule

// ===== bench/ibfd_record_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibfd_record_checker
// Watches the byte, record and configuration channels of the burst frame
// decoder. It decodes every accepted item with its own copy of the frame
// state, queues the record words it should produce, and compares each word
// that leaves the block, field by field, with the oldest queued word.
// ----------------------------------------------------------------------------
module ibfd_record_checker
  import ibfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser_i,   // [0] opcode, [1] frame_start
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,   // [14:0] word_value, [15] zero
  input  logic [5:0]  m_axis_tuser_i,   // [3:0] word_index, [4] frame_good,
                                        // [5] sensor_reset
  input  logic        m_axis_tlast_i,   // last_word
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [13:0] cfg_data_i,
  output int          mismatches_o,
  output int          words_outstanding_o
);

  ibfd_cfg_t    window_cfg;
  ibfd_result_t expected_words_q[$];
  int           mismatch_count;

  // Frame state as the block should hold it
  logic [4:0]  byte_pos;
  logic [7:0]  held_high;
  logic        frame_ok;
  logic        frame_skipped;
  logic [11:0] bad_frames;
  logic [9:0]  holdoff_left;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Advance the frame state by one accepted item; queue the word it completes.
  task automatic decode_item(input logic opcode, input logic frame_start,
                             input logic [7:0] rx_byte);
    logic [4:0]   pos;
    logic [3:0]   word;
    logic [13:0]  raw14;
    logic [11:0]  raw12;
    logic [12:0]  next_count;
    logic         pulse;
    ibfd_result_t word_r;
    if (opcode == OP_TICK) begin
      if (holdoff_left != '0) holdoff_left--;
    end else begin
      if (frame_start || byte_pos > LAST_BYTE_POS) byte_pos = '0;
      pos = byte_pos;
      if (pos == '0) begin
        frame_skipped = (holdoff_left != '0);
        frame_ok      = 1'b0;
      end
      byte_pos = (pos == LAST_BYTE_POS) ? 5'd0 : pos + 5'd1;
      if (!frame_skipped) begin
        if (!pos[0]) begin
          held_high = rx_byte;
        end else begin
          word  = pos[4:1];
          raw14 = {held_high[5:0], rx_byte};
          raw12 = {held_high[3:0], rx_byte};
          pulse = 1'b0;
          if (word == WORD_SUPPLY) begin
            word_r.word_value = {1'b0, raw14};
            frame_ok = (raw14 >= window_cfg.supply_min_count) &&
                       (raw14 <= window_cfg.supply_max_count);
            if (!frame_ok) begin
              // the limit test is one bit wider than the counter
              next_count = {1'b0, bad_frames} + 13'd1;
              if (next_count > {1'b0, window_cfg.bad_frame_limit}) begin
                pulse        = 1'b1;
                bad_frames   = '0;
                holdoff_left = window_cfg.holdoff_ticks;
              end else begin
                bad_frames = next_count[11:0];
              end
            end
          end else if (word <= WORD_LAST_IMU) begin
            word_r.word_value = {raw14[13], raw14};
          end else if (word == WORD_TEMP) begin
            word_r.word_value = {{3{raw12[11]}}, raw12};
          end else begin
            word_r.word_value = {3'b000, raw12};
          end
          word_r.word_index   = word;
          word_r.frame_good   = frame_ok;
          word_r.sensor_reset = pulse;
          word_r.last_word    = (word == WORD_ADC);
          expected_words_q.push_back(word_r);
        end
      end
    end
  endtask

  task automatic check_word();
    ibfd_result_t exp_r;
    if (expected_words_q.size() == 0) begin
      report_mismatch($sformatf("word %0d arrived with nothing expected",
                                m_axis_tuser_i[3:0]));
    end else begin
      exp_r = expected_words_q.pop_front();
      if (m_axis_tuser_i[3:0] !== exp_r.word_index)
        report_mismatch($sformatf("word_index got %0d want %0d",
                                  m_axis_tuser_i[3:0], exp_r.word_index));
      if (m_axis_tdata_i !== {1'b0, exp_r.word_value})
        report_mismatch($sformatf("word %0d word_value got %h want %h",
                                  exp_r.word_index, m_axis_tdata_i,
                                  {1'b0, exp_r.word_value}));
      if (m_axis_tuser_i[4] !== exp_r.frame_good)
        report_mismatch($sformatf("word %0d frame_good got %b want %b",
                                  exp_r.word_index, m_axis_tuser_i[4],
                                  exp_r.frame_good));
      if (m_axis_tuser_i[5] !== exp_r.sensor_reset)
        report_mismatch($sformatf("word %0d sensor_reset got %b want %b",
                                  exp_r.word_index, m_axis_tuser_i[5],
                                  exp_r.sensor_reset));
      if (m_axis_tlast_i !== exp_r.last_word)
        report_mismatch($sformatf("word %0d last_word got %b want %b",
                                  exp_r.word_index, m_axis_tlast_i,
                                  exp_r.last_word));
    end
  endtask

  // Sample at the edge: stimulus moves only by nonblocking assignment.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      window_cfg.supply_min_count = SUPPLY_MIN_RST;
      window_cfg.supply_max_count = SUPPLY_MAX_RST;
      window_cfg.bad_frame_limit  = BAD_LIMIT_RST;
      window_cfg.holdoff_ticks    = HOLDOFF_RST;
      byte_pos      = '0;
      held_high     = '0;
      frame_ok      = 1'b0;
      frame_skipped = 1'b0;
      bad_frames    = '0;
      holdoff_left  = '0;
      expected_words_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SUPPLY_MIN: window_cfg.supply_min_count = cfg_data_i;
          REG_SUPPLY_MAX: window_cfg.supply_max_count = cfg_data_i;
          REG_BAD_LIMIT:  window_cfg.bad_frame_limit  = cfg_data_i[11:0];
          REG_HOLDOFF:    window_cfg.holdoff_ticks    = cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid_i && m_axis_tready_i) check_word();
      if (s_axis_tvalid_i && s_axis_tready_i)
        decode_item(s_axis_tuser_i[0], s_axis_tuser_i[1], s_axis_tdata_i);
    end
    mismatches_o        <= mismatch_count;
    words_outstanding_o <= expected_words_q.size();
  end

endmodule

// ===== bench/tb_imu_burst_frame_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_imu_burst_frame_decoder
// Drives bursts of sensor response bytes and millisecond ticks into the
// decoder under random stalls on both streams, moves the supply window,
// bad frame limit and holdoff through their extremes between phases, and
// takes the verdict from the record checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb_imu_burst_frame_decoder;
  import ibfd_pkg::*;

  // No transaction on any channel for this long means the block is stuck.
  localparam int WATCHDOG_LIMIT = 1000;
  // Cycles to let result-free items (ticks, high bytes) clear the pipeline.
  localparam int DRAIN_CYCLES   = 6;

  // Directed burst, first byte leftmost: a supply count on the lower window
  // edge with the unused top bits set, then the 14-bit extremes, the 12-bit
  // temperature minimum and the full-scale ADC reading.
  localparam logic [191:0] DIRECTED_FRAME =
    192'hC6DE_1FFF_2000_3FFF_0000_FFFF_4001_8080_55AA_AA55_F800_0FFF;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [5:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index     = '0;
  logic [13:0] cfg_data      = '0;

  int          mismatches;
  int          words_outstanding;
  int          quiet_cycles = 0;

  // Set during one phase to hold both streams free of idle cycles.
  bit          steady = 1'b0;
  // Supply window as last written, used to aim supply counts at its edges.
  logic [13:0] cur_min = SUPPLY_MIN_RST;
  logic [13:0] cur_max = SUPPLY_MAX_RST;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  imu_burst_frame_decoder i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .m_axis_tlast_o  (m_axis_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  ibfd_record_checker i_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .s_axis_tvalid_i     (s_axis_tvalid),
    .s_axis_tready_i     (s_axis_tready),
    .s_axis_tdata_i      (s_axis_tdata),
    .s_axis_tuser_i      (s_axis_tuser),
    .m_axis_tvalid_i     (m_axis_tvalid),
    .m_axis_tready_i     (m_axis_tready),
    .m_axis_tdata_i      (m_axis_tdata),
    .m_axis_tuser_i      (m_axis_tuser),
    .m_axis_tlast_i      (m_axis_tlast),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .mismatches_o        (mismatches),
    .words_outstanding_o (words_outstanding)
  );

  // Stall the record stream in about a third of the cycles.
  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);
  end

  // Count cycles without any transaction; give up when the block hangs.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Offer one item, idling at random first; return after its transaction.
  task automatic send_item(input logic opcode, input logic frame_start,
                           input logic [7:0] rx_byte);
    while (!steady && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {frame_start, opcode};
    s_axis_tdata  <= rx_byte;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [13:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  // Hold input until every queued word is out and the pipeline is empty.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (words_outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_window(input logic [13:0] min_count, input logic [13:0] max_count,
                            input logic [11:0] bad_limit, input logic [9:0] holdoff);
    drain();
    write_reg(REG_SUPPLY_MIN, min_count);
    write_reg(REG_SUPPLY_MAX, max_count);
    write_reg(REG_BAD_LIMIT, {2'b00, bad_limit});
    write_reg(REG_HOLDOFF, {4'h0, holdoff});
    cfg_valid <= 1'b0;
    cur_min = min_count;
    cur_max = max_count;
  endtask

  // Send one burst with random content. The supply count lands inside the
  // window, anywhere, or on or just past an edge; a few bursts are cut short or
  // lack the start mark, and ticks fall between bytes.
  task automatic send_frame(input int unsigned tick_pct);
    logic [13:0] supply;
    int unsigned len;
    logic        mark_start;
    case ($urandom_range(0, 3))
      0, 1: begin
        if (cur_min <= cur_max) supply = 14'($urandom_range(cur_min, cur_max));
        else supply = 14'($urandom_range(0, 16383));
      end
      2: supply = 14'($urandom_range(0, 16383));
      default: begin
        case ($urandom_range(0, 3))
          0: supply = cur_min - 14'd1;
          1: supply = cur_min;
          2: supply = cur_max;
          default: supply = cur_max + 14'd1;
        endcase
      end
    endcase
    len        = ($urandom_range(0, 99) < 85) ? 24 : $urandom_range(1, 23);
    mark_start = ($urandom_range(0, 99) < 90);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < tick_pct)
        send_item(OP_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      if (i == 0)
        send_item(OP_BYTE, mark_start, {2'($urandom_range(0, 3)), supply[13:8]});
      else if (i == 1)
        send_item(OP_BYTE, 1'b0, supply[7:0]);
      else
        send_item(OP_BYTE, 1'b0, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: one full burst of extremes under the reset window, a tick,
    // then a burst restarted after its supply word and one more high byte.
    for (int i = 0; i < 24; i++) begin
      send_item(OP_BYTE, i == 0, DIRECTED_FRAME[(23 - i) * 8 +: 8]);
    end
    send_item(OP_TICK, 1'b1, 8'hFF);
    send_item(OP_BYTE, 1'b1, 8'h08);
    send_item(OP_BYTE, 1'b0, 8'h7B);   // upper window edge, good
    send_item(OP_BYTE, 1'b0, 8'h12);
    send_item(OP_BYTE, 1'b1, 8'h08);   // restart mid-frame
    send_item(OP_BYTE, 1'b0, 8'h7C);   // one past the upper edge, bad
    for (int f = 0; f < 5; f++) send_frame(5);

    // Widest window: every burst is good.
    set_window(14'd0, 14'd16383, 12'd4095, 10'd1023);
    for (int f = 0; f < 4; f++) send_frame(5);

    // Empty window, reset on every bad burst, short holdoff: bursts start
    // both inside and after the holdoff depending on the ticks between.
    set_window(14'd2000, 14'd1000, 12'd0, 10'd3);
    for (int f = 0; f < 6; f++) send_frame(12);

    // Zero holdoff with a small limit; run both streams without idling.
    steady = 1'b1;
    set_window(14'd1758, 14'd1800, 12'd2, 10'd0);
    for (int f = 0; f < 6; f++) send_frame(8);
    steady = 1'b0;

    // Long holdoff: bursts stay ignored until 30 ticks have passed.
    set_window(14'd16383, 14'd0, 12'd0, 10'd30);
    send_frame(0);
    for (int f = 0; f < 2; f++) send_frame(0);
    for (int t = 0; t < 30; t++) send_item(OP_TICK, 1'b0, 8'($urandom_range(0, 255)));
    for (int f = 0; f < 2; f++) send_frame(0);

    // Limit of twenty: the 21st bad burst in a row requests a sensor reset.
    // Clear the holdoff left over first, then cut each burst after its
    // supply word.
    set_window(14'd16383, 14'd0, 12'd20, 10'd1);
    for (int t = 0; t < 30; t++) send_item(OP_TICK, 1'b0, 8'($urandom_range(0, 255)));
    for (int f = 0; f < 21; f++) begin
      send_item(OP_BYTE, 1'b1, 8'($urandom_range(0, 255)));
      send_item(OP_BYTE, 1'b0, 8'($urandom_range(0, 255)));
    end
    send_item(OP_BYTE, 1'b1, 8'($urandom_range(0, 255)));   // inside holdoff
    send_item(OP_BYTE, 1'b0, 8'($urandom_range(0, 255)));
    send_item(OP_TICK, 1'b0, 8'($urandom_range(0, 255)));
    send_item(OP_BYTE, 1'b1, 8'($urandom_range(0, 255)));
    send_item(OP_BYTE, 1'b0, 8'($urandom_range(0, 255)));

    // Random settings near the reset window, with stray items between bursts.
    for (int p = 0; p < 2; p++) begin
      set_window(14'($urandom_range(1500, 2000)), 14'($urandom_range(1900, 2400)),
                 12'($urandom_range(0, 4)), 10'($urandom_range(0, 12)));
      for (int f = 0; f < 2; f++) begin
        send_frame(15);
        for (int n = 0; n < 2; n++)
          send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    8'($urandom_range(0, 255)));
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
